// File: src/rat_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the rational accumulator.
// Depends on nothing.
package rat_pkg;

  // Width of every numerator and denominator field on the stream ports.
  localparam int unsigned FieldW = 32;

  // Request codes carried in the slave-side tuser.
  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REDUCE = 2'd2,
    REQ_FLIP   = 2'd3
  } req_e;

endpackage

// File: src/rational_accumulator.sv
`timescale 1ns / 1ps
// Rational accumulator: holds one signed fraction, reset to 1/1. Depends on rat_pkg.
// Set, flip and an add with a zero denominator go straight from acceptance to the done
// state; reduce and add run a binary gcd, then restoring divisions and shift-add multiplies
// of WORD_WIDTH steps each (reduce stops after the gcd when it is at most 1). One word is
// in work at a time; s_axis_tready is high only while idle. rst_ni clears the sequencer
// and the output valid, and sets the fraction to 1/1.
module rational_accumulator
  import rat_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request word.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*FieldW-1:0] s_axis_tdata,  // in_num [31:0], in_den [63:32]
  input  logic [1:0]          s_axis_tuser,  // req_type [1:0]
  // Result word.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [2*FieldW-1:0] m_axis_tdata,  // out_num [31:0], out_den [63:32]
  output logic                m_axis_tuser   // ok [0]
);

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned CW = $clog2(WORD_WIDTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV_LD,
    ST_DIV_RUN,
    ST_MUL_LD,
    ST_MUL_RUN,
    ST_DONE
  } state_e;

  state_e          state_q;
  req_e            op_q;
  logic [W-1:0]    num_q, den_q;
  logic [W-1:0]    opn_q, opd_q;
  logic [W-1:0]    ma_q, mb_q;
  logic [W-1:0]    a_q, b_q, g_q;
  logic [CW-1:0]   k_q, cnt_q;
  logic [1:0]      idx_q;
  logic [W-1:0]    rem_q;
  logic [W-1:0]    dq_q;
  logic [W-1:0]    q1_q, q2_q;
  logic [W-1:0]    mc_q, mp_q, acc_q, sum_q;
  logic            ok_q;
  logic            ovalid_q;
  logic [FieldW-1:0] onum_q, oden_q;
  logic            ook_q;

  // Operand words wrapped to the internal width.
  logic [W-1:0] in_num_w, in_den_w;
  assign in_num_w = W'($signed(s_axis_tdata[FieldW-1:0]));
  assign in_den_w = W'($signed(s_axis_tdata[2*FieldW-1:FieldW]));

  // Magnitudes of the stored parts and the operand denominator.
  logic [W-1:0] mag_num, mag_den, mag_ind;
  assign mag_num = num_q[W-1] ? W'(-num_q) : num_q;
  assign mag_den = den_q[W-1] ? W'(-den_q) : den_q;
  assign mag_ind = in_den_w[W-1] ? W'(-in_den_w) : in_den_w;

  // Binary gcd step and its two subtractors.
  logic         a_ge_b;
  logic [W-1:0] a_m_b, b_m_a, gcd_res;
  assign a_ge_b  = a_q >= b_q;
  assign a_m_b   = a_q - b_q;
  assign b_m_a   = b_q - a_q;
  assign gcd_res = (a_q == '0) ? (b_q << k_q) : (a_q << k_q);

  // Restoring division step; the remainder always stays below the divisor.
  logic [W:0]   trial;
  logic         qbit;
  logic [W-1:0] dq_next;
  assign trial   = {rem_q, dq_q[W-1]};
  assign qbit    = trial >= {1'b0, g_q};
  assign dq_next = {dq_q[W-2:0], qbit};

  // Shift-add multiply step and the signed product once finished.
  logic [W-1:0] acc_next, prod;
  logic         prod_neg;
  assign acc_next = mp_q[0] ? acc_q + mc_q : acc_q;
  assign prod_neg = (idx_q == 2'd0) ? den_q[W-1] : ((idx_q == 2'd1) ? opd_q[W-1] : 1'b0);
  assign prod     = prod_neg ? W'(-acc_next) : acc_next;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {oden_q, onum_q};
  assign m_axis_tuser  = ook_q;

  // Sequencer, fraction state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      num_q    <= W'(1);
      den_q    <= W'(1);
      ovalid_q <= 1'b0;
      ok_q     <= 1'b0;
      op_q     <= REQ_SET;
      idx_q    <= '0;
      cnt_q    <= '0;
      k_q      <= '0;
    end else begin
      if (ovalid_q && m_axis_tready && state_q != ST_DONE) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q  <= req_e'(s_axis_tuser);
            opn_q <= in_num_w;
            opd_q <= in_den_w;
            ok_q  <= 1'b0;
            k_q   <= '0;
            state_q <= ST_DONE;
            unique case (req_e'(s_axis_tuser))
              REQ_SET: begin
                if (in_den_w != '0) begin
                  num_q <= in_num_w;
                  den_q <= in_den_w;
                  ok_q  <= 1'b1;
                end
              end
              REQ_ADD: begin
                if (in_den_w != '0 && den_q != '0) begin
                  ma_q    <= mag_den;
                  mb_q    <= mag_ind;
                  a_q     <= mag_den;
                  b_q     <= mag_ind;
                  state_q <= ST_GCD;
                end
              end
              REQ_REDUCE: begin
                ma_q    <= mag_num;
                mb_q    <= mag_den;
                a_q     <= mag_num;
                b_q     <= mag_den;
                state_q <= ST_GCD;
              end
              REQ_FLIP: begin
                if (num_q != '0) begin
                  num_q <= den_q;
                  den_q <= num_q;
                  ok_q  <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_GCD: begin
          priority if (a_q == '0 || b_q == '0) begin
            g_q   <= gcd_res;
            idx_q <= '0;
            if (op_q == REQ_REDUCE && gcd_res <= W'(1)) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_DIV_LD;
            end
          end else if (!a_q[0] && !b_q[0]) begin
            a_q <= a_q >> 1;
            b_q <= b_q >> 1;
            k_q <= k_q + CW'(1);
          end else if (!a_q[0]) begin
            a_q <= a_q >> 1;
          end else if (!b_q[0]) begin
            b_q <= b_q >> 1;
          end else if (a_ge_b) begin
            a_q <= a_m_b;
          end else begin
            b_q <= b_m_a;
          end
        end
        ST_DIV_LD: begin
          rem_q <= '0;
          cnt_q <= '0;
          if ((op_q == REQ_ADD) == (idx_q == 2'd0)) begin
            dq_q <= mb_q;
          end else begin
            dq_q <= ma_q;
          end
          state_q <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          rem_q <= qbit ? W'(trial - {1'b0, g_q}) : trial[W-1:0];
          dq_q  <= dq_next;
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(W - 1)) begin
            if (idx_q == 2'd0) begin
              q1_q    <= dq_next;
              idx_q   <= 2'd1;
              state_q <= ST_DIV_LD;
            end else if (op_q == REQ_REDUCE) begin
              num_q   <= num_q[W-1] ? W'(-q1_q) : q1_q;
              den_q   <= den_q[W-1] ? W'(-dq_next) : dq_next;
              ok_q    <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              q2_q    <= dq_next;
              idx_q   <= 2'd0;
              sum_q   <= '0;
              state_q <= ST_MUL_LD;
            end
          end
        end
        ST_MUL_LD: begin
          acc_q <= '0;
          cnt_q <= '0;
          unique case (idx_q)
            2'd0: begin
              mc_q <= num_q;
              mp_q <= q1_q;
            end
            2'd1: begin
              mc_q <= opn_q;
              mp_q <= q2_q;
            end
            default: begin
              mc_q <= mb_q;
              mp_q <= q2_q;
            end
          endcase
          state_q <= ST_MUL_RUN;
        end
        ST_MUL_RUN: begin
          acc_q <= acc_next;
          mc_q  <= mc_q << 1;
          mp_q  <= mp_q >> 1;
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(W - 1)) begin
            if (idx_q == 2'd2) begin
              num_q   <= sum_q;
              den_q   <= prod;
              ok_q    <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              sum_q   <= sum_q + prod;
              idx_q   <= idx_q + 2'd1;
              state_q <= ST_MUL_LD;
            end
          end
        end
        ST_DONE: begin
          if (!ovalid_q || m_axis_tready) begin
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result payload, loaded as the word is handed to the output register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!ovalid_q || m_axis_tready)) begin
      onum_q <= FieldW'($signed(num_q));
      oden_q <= FieldW'($signed(den_q));
      ook_q  <= ok_q;
    end
  end

endmodule
